/* hdl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, sizes and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int DATA_WIDTH     = 32;
    localparam int PRIORITY_WIDTH = 16;
    localparam int COUNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

    typedef logic signed [PRIORITY_WIDTH-1:0] prio_t;
    typedef logic [DATA_WIDTH-1:0]            data_t;

    // one stored entry
    typedef struct packed {
        logic  valid;
        prio_t prio;
        data_t data;
    } entry_t;

    // command broadcast to every cell
    typedef struct packed {
        logic  push;
        logic  pop;
        prio_t prio;
        data_t data;
    } cell_cmd_t;

endpackage

/* hdl/sorted_priority_queue.sv */
`timescale 1ns / 1ps
// The result word is registered and appears in the cycle after its command word is accepted.
// Throughput: one command per cycle while s_ready is high; every cell compares and shifts at once.
// s_ready drops only while a result word waits and m_ready is low.
// Reset (aresetn, synchronous, active low) empties the queue at once.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue as a row of cells sorted by ascending priority.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [31:0] s_item_data,
    input  logic signed [15:0] s_priority_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_popped_data,
    output logic        m_head_valid,
    output logic signed [15:0] m_head_priority,
    output logic [31:0] m_head_data,
    output logic [4:0]  m_occupancy
);
    import spq_pkg::*;

    logic                   accept;
    logic                   is_push;
    logic                   is_pop;
    logic                   full;
    logic                   empty;
    cell_cmd_t              cmd;
    entry_t                 cell_entry [QUEUE_DEPTH];
    entry_t                 cell_next  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_keep;
    logic [QUEUE_DEPTH-1:0] valid_vec;
    logic [QUEUE_DEPTH-1:0] order_ok;

    logic [COUNT_WIDTH-1:0] count_reg, count_next;

    logic        m_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [31:0] popped_reg, popped_next;
    logic        head_valid_reg;
    logic signed [15:0] head_prio_reg;
    logic [31:0] head_data_reg;
    logic [4:0]  occ_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == COUNT_WIDTH'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign is_push = accept && (s_command == CMD_PUSH);
    assign is_pop  = accept && (s_command == CMD_POP);

    assign cmd.push = is_push && !full;
    assign cmd.pop  = is_pop && !empty;
    assign cmd.prio = PRIORITY_WIDTH'(s_priority_req);
    assign cmd.data = DATA_WIDTH'(s_item_data);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_k;

            if (gi == 0) begin : g_head
                // head cell: the new word lands here unless the head stays
                assign left_e = '{valid: 1'b1, prio: cmd.prio, data: cmd.data};
                assign left_k = 1'b1;
            end else begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_k = cell_keep[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign right_e = '{valid: 1'b0, prio: '0, data: '0};
            end else begin : g_body
                assign right_e = cell_entry[gi+1];
            end

            spq_cell u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .cmd          (cmd),
                .left_entry   (left_e),
                .left_keep    (left_k),
                .right_entry  (right_e),
                .entry_o      (cell_entry[gi]),
                .entry_next_o (cell_next[gi]),
                .keep_o       (cell_keep[gi])
            );

            assign valid_vec[gi] = cell_entry[gi].valid;

            if (gi == 0) begin : g_ord0
                assign order_ok[gi] = 1'b1;
            end else begin : g_ordn
                assign order_ok[gi] = !cell_entry[gi].valid ||
                                      (cell_entry[gi-1].prio <= cell_entry[gi].prio);
            end
        end
    endgenerate

    always_comb begin
        count_next  = count_reg;
        status_next = STATUS_OK;
        popped_next = '0;
        if (is_push) begin
            if (full) begin
                status_next = STATUS_OVERFLOW;
            end else begin
                count_next = count_reg + COUNT_WIDTH'(1);
            end
        end else if (is_pop) begin
            if (empty) begin
                status_next = STATUS_UNDERFLOW;
            end else begin
                count_next  = count_reg - COUNT_WIDTH'(1);
                popped_next = 32'(cell_entry[0].data);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word: head and occupancy as they stand after the command
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status_next;
            popped_reg     <= popped_next;
            head_valid_reg <= cell_next[0].valid;
            head_prio_reg  <= cell_next[0].valid ? 16'(cell_next[0].prio) : '0;
            head_data_reg  <= cell_next[0].valid ? 32'(cell_next[0].data) : '0;
            occ_reg        <= 5'(count_next);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = status_reg;
    assign m_popped_data   = popped_reg;
    assign m_head_valid    = head_valid_reg;
    assign m_head_priority = head_prio_reg;
    assign m_head_data     = head_data_reg;
    assign m_occupancy     = occ_reg;

    // occupied cells match the count
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == COUNT_WIDTH'($countones(valid_vec)))
        else $error("entry count disagrees with occupied cells");

    // occupied cells form an unbroken run from the head
    a_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_vec & (valid_vec + QUEUE_DEPTH'(1))) == '0)
        else $error("gap in occupied cells");

    // held entries stay in ascending priority order
    a_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        &order_ok)
        else $error("queue entries out of order");

    // a push on a full queue leaves the contents alone
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (is_push && full) |=> ($stable(count_reg) && $stable(valid_vec)))
        else $error("push on full queue changed the queue");

endmodule

/* hdl/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry, compares it with the pushed
// priority and takes its neighbour's entry on a shift.
// ----------------------------------------------------------------------------
module spq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  spq_pkg::cell_cmd_t cmd,
    input  spq_pkg::entry_t    left_entry,
    input  logic               left_keep,
    input  spq_pkg::entry_t    right_entry,
    output spq_pkg::entry_t    entry_o,
    output spq_pkg::entry_t    entry_next_o,
    output logic               keep_o
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   keep;

    // entry stays ahead of the new word; equal priorities keep arrival order
    assign keep = entry_reg.valid && (entry_reg.prio <= cmd.prio);

    always_comb begin
        entry_next = entry_reg;
        if (cmd.push) begin
            if (!keep) begin
                if (left_keep) begin
                    entry_next.prio = cmd.prio;
                    entry_next.data = cmd.data;
                end else begin
                    entry_next.prio = left_entry.prio;
                    entry_next.data = left_entry.data;
                end
                entry_next.valid = entry_reg.valid | left_entry.valid;
            end
        end else if (cmd.pop) begin
            entry_next = right_entry;
        end
    end

    // only the valid bit is reset; contents are don't-care while empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.valid <= 1'b0;
        end else begin
            entry_reg.valid <= entry_next.valid;
        end
        entry_reg.prio <= entry_next.prio;
        entry_reg.data <= entry_next.data;
    end

    assign entry_o      = entry_reg;
    assign entry_next_o = entry_next;
    assign keep_o       = keep;

endmodule

/* sim/tb_sorted_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A directed opening walks
// the empty and full corners, ties and extreme priorities. Random push/pop
// bursts then fill and drain the queue over and over. Both channels idle at
// random. Each result word is checked against a behavioural queue model.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic  cmd;
        data_t data;
        prio_t prio;
    } cmd_word_t;

    typedef struct packed {
        logic [1:0]             status;
        data_t                  popped;
        logic                   head_valid;
        prio_t                  head_prio;
        data_t                  head_data;
        logic [COUNT_WIDTH-1:0] occupancy;
    } result_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_PUSH;
    logic [31:0] s_item_data = '0;
    logic signed [15:0] s_priority_req = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_status;
    logic [31:0] m_popped_data;
    logic        m_head_valid;
    logic signed [15:0] m_head_priority;
    logic [31:0] m_head_data;
    logic [4:0]  m_occupancy;

    sorted_priority_queue uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_item_data     (s_item_data),
        .s_priority_req  (s_priority_req),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_popped_data   (m_popped_data),
        .m_head_valid    (m_head_valid),
        .m_head_priority (m_head_priority),
        .m_head_data     (m_head_data),
        .m_occupancy     (m_occupancy)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // behavioural copy of the queue, head first
    prio_t queue_prio [QUEUE_DEPTH];
    data_t queue_data [QUEUE_DEPTH];
    int    queue_fill = 0;

    cmd_word_t    pending_cmds [$];
    result_word_t expected_words [$];

    int  total_cmds = 0;
    int  n_accepted = 0;
    int  n_checked = 0;
    int  mismatches = 0;
    int  n_push = 0, n_pop = 0, n_overflow = 0, n_underflow = 0, peak_fill = 0;
    longint cycles = 0;

    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    int   in_wait = 0, out_wait = 0;
    int   n_in = 0, n_out = 0;
    bit   in_quiet = 1'b0, out_quiet = 1'b0;

    function automatic result_word_t queue_apply(cmd_word_t w);
        result_word_t r;
        int pos;
        int i;
        r = '0;
        if (w.cmd == CMD_PUSH) begin
            if (queue_fill >= QUEUE_DEPTH) begin
                r.status = STATUS_OVERFLOW;
            end else begin
                // new entry goes behind every entry of equal or lower priority
                pos = 0;
                while (pos < queue_fill && queue_prio[pos] <= w.prio) pos++;
                for (i = queue_fill; i > pos; i--) begin
                    queue_prio[i] = queue_prio[i-1];
                    queue_data[i] = queue_data[i-1];
                end
                queue_prio[pos] = w.prio;
                queue_data[pos] = w.data;
                queue_fill++;
            end
        end else begin
            if (queue_fill == 0) begin
                r.status = STATUS_UNDERFLOW;
            end else begin
                r.popped = queue_data[0];
                for (i = 1; i < queue_fill; i++) begin
                    queue_prio[i-1] = queue_prio[i];
                    queue_data[i-1] = queue_data[i];
                end
                queue_fill--;
            end
        end
        if (queue_fill > 0) begin
            r.head_valid = 1'b1;
            r.head_prio  = queue_prio[0];
            r.head_data  = queue_data[0];
        end
        r.occupancy = COUNT_WIDTH'(queue_fill);
        return r;
    endfunction

    task automatic add_cmd(logic c, data_t d, prio_t p);
        pending_cmds.push_back('{cmd: c, data: d, prio: p});
        total_cmds++;
    endtask

    function automatic prio_t rand_prio(int mode);
        int v;
        case (mode)
            0: begin
                v = $urandom_range(0, 6);
                return prio_t'(v - 3);
            end
            1: begin
                case ($urandom_range(0, 3))
                    0: return prio_t'(16'h8000);
                    1: return prio_t'(16'h7FFF);
                    2: return prio_t'(16'h8001);
                    default: return prio_t'(16'h7FFE);
                endcase
            end
            default: return prio_t'($urandom);
        endcase
    endfunction

    task automatic check_field(string fname, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("word %0d %s: expected %h, got %h", n_checked, fname, want, got);
        end
    endtask

    // driver: new word on the falling edge once the previous one has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // hold the word until accepted
        end else if (in_wait > 0) begin
            in_wait--;
            s_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
            cmd_word_t w;
            w = pending_cmds.pop_front();
            s_command      <= w.cmd;
            s_item_data    <= w.data;
            s_priority_req <= w.prio;
            s_valid        <= 1'b1;
            n_in++;
            if (n_in % 64 == 0) in_quiet = ($urandom_range(0, 3) == 0);
            in_wait = in_quiet ? 0 : $urandom_range(0, 16);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // receiver: stall counts down only while a result word is waiting
    always @(negedge aclk) begin
        if (out_taken) begin
            n_out++;
            if (n_out % 64 == 0) out_quiet = ($urandom_range(0, 3) == 0);
            out_wait = out_quiet ? 0 : $urandom_range(0, 16);
        end
        if (m_valid && out_wait > 0) out_wait--;
        m_ready <= (out_wait == 0);
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge aclk) begin
        in_taken  <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready) begin
            cmd_word_t    w;
            result_word_t r;
            w = '{cmd: s_command, data: s_item_data, prio: s_priority_req};
            r = queue_apply(w);
            expected_words.push_back(r);
            n_accepted++;
            if (w.cmd == CMD_PUSH) n_push++; else n_pop++;
            if (r.status == STATUS_OVERFLOW) n_overflow++;
            if (r.status == STATUS_UNDERFLOW) n_underflow++;
            if (queue_fill > peak_fill) peak_fill = queue_fill;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word with nothing outstanding");
            end else begin
                result_word_t e;
                e = expected_words.pop_front();
                check_field("status", m_status, e.status);
                check_field("popped_data", m_popped_data, e.popped);
                check_field("head_valid", m_head_valid, e.head_valid);
                check_field("head_priority", m_head_priority, e.head_prio);
                check_field("head_data", m_head_data, e.head_data);
                check_field("occupancy", m_occupancy, e.occupancy);
                n_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timed out with %0d words outstanding", expected_words.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int n_random;
        int seg_len;
        int push_pct;
        int prio_mode;
        int k;

        // directed opening: empty pop, ties, extremes, fill to the brim, overflow
        add_cmd(CMD_POP, 32'hFFFF_FFFF, prio_t'(16'h7FFF));
        add_cmd(CMD_PUSH, 32'hFFFF_FFFF, prio_t'(16'h7FFF));
        add_cmd(CMD_PUSH, 32'h0000_0000, prio_t'(16'h8000));
        add_cmd(CMD_PUSH, 32'h0000_0001, prio_t'(16'h0000));
        add_cmd(CMD_PUSH, 32'h0000_0002, prio_t'(16'h0000));
        add_cmd(CMD_PUSH, 32'h0000_0003, prio_t'(16'h8000));
        add_cmd(CMD_PUSH, 32'hAAAA_AAAA, prio_t'(16'hFFFF));
        add_cmd(CMD_PUSH, 32'h5555_5555, prio_t'(16'h0001));
        add_cmd(CMD_PUSH, 32'h0000_0004, prio_t'(16'h7FFF));
        add_cmd(CMD_PUSH, 32'h0000_0005, prio_t'(16'h0000));
        for (k = 0; k < 7; k++) add_cmd(CMD_PUSH, $urandom, prio_t'($urandom));
        add_cmd(CMD_PUSH, 32'hDEAD_0001, prio_t'(16'h8000));
        add_cmd(CMD_PUSH, 32'hDEAD_0002, prio_t'(16'h7FFF));
        for (k = 0; k < 4; k++) add_cmd(CMD_POP, 32'h0, prio_t'(16'h0));

        // random bursts leaning towards push, towards pop or balanced so the queue fills and drains
        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            seg_len = $urandom_range(8, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 25;
                1: push_pct = 50;
                default: push_pct = 80;
            endcase
            prio_mode = $urandom_range(0, 2);
            for (k = 0; k < seg_len; k++) begin
                if ($urandom_range(0, 99) < push_pct)
                    add_cmd(CMD_PUSH, $urandom, rand_prio(prio_mode));
                else
                    add_cmd(CMD_POP, $urandom, prio_t'($urandom));
                n_random++;
            end
        end

        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < total_cmds) @(posedge aclk);
        while (expected_words.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        mismatches += expected_words.size();

        $display("%0d commands (%0d push, %0d pop), %0d result words checked",
                 total_cmds, n_push, n_pop, n_checked);
        $display("%0d overflows, %0d underflows, peak occupancy %0d, %0d mismatches",
                 n_overflow, n_underflow, peak_fill, mismatches);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
sim/tb_sorted_priority_queue.sv
